// ----- rtl/umsa_pkg.sv -----
package umsa_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int SIZE_W       = 13;
   localparam int GRID_W       = 9;
   localparam int COEF_W       = 31;
   localparam int CSR_INDEX_W  = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int STEP_W       = 4;
   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 256;

   localparam logic [STEP_W-1:0] LAST_STEP = 4'd9;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic signed [51:0] RES_HI = (52'sd1 <<< (DATA_WIDTH - 1)) - 52'sd1;
   localparam logic signed [51:0] RES_LO = -RES_HI - 52'sd1;
   localparam logic signed [51:0] COEF_HI = 52'sd2147483647;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH     = 3'd0,
      CSR_GRID_HEIGHT    = 3'd1,
      CSR_COMPONENT_SEL  = 3'd2,
      CSR_DIFFUSION_X    = 3'd3,
      CSR_DIFFUSION_Y    = 3'd4,
      CSR_FLUX_SCALE_X   = 3'd5,
      CSR_FLUX_SCALE_Y   = 3'd6,
      CSR_GRADIENT_SCALE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_width;
      logic [GRID_W-1:0] grid_height;
      logic              component_select;
      logic [COEF_W-1:0] diffusion_x;
      logic [COEF_W-1:0] diffusion_y;
      logic [COEF_W-1:0] flux_scale_x;
      logic [COEF_W-1:0] flux_scale_y;
      logic [COEF_W-1:0] gradient_scale;
   } cfg_type;

   typedef struct packed {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] pr;
   } cell_type;

   typedef struct packed {
      logic       interior;
      logic       boundary;
      logic       fold_e;
      logic       fold_w;
      logic       fold_n;
      logic       fold_s;
      logic [7:0] row;
      logic [7:0] col;
      cell_type   cur;
      cell_type   ctr;
      cell_type   est;
      cell_type   wst;
      cell_type   sth;
   } job_type;

   typedef enum logic {
      F_IDLE,
      F_READ
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CALC,
      B_FIN,
      B_INT,
      B_BND
   } back_state_type;

endpackage

// ----- rtl/umsa_ram.sv -----
module umsa_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ----- rtl/umsa_queue.sv -----
module umsa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  umsa_pkg::job_type push_data,
   input  logic              pop,
   output umsa_pkg::job_type head,
   output logic              full,
   output logic              empty
);

   localparam int PW = $clog2(umsa_pkg::QUEUE_DEPTH);

   umsa_pkg::job_type entry_ff [umsa_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign full  = (count_ff == (PW+1)'(umsa_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/umsa_front.sv -----
module umsa_front #(
   parameter int MAX_WIDTH  = umsa_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = umsa_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  umsa_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_vel_x,
   input  logic [31:0]       req_vel_y,
   input  logic [31:0]       req_cell_pressure,
   output logic              push,
   output umsa_pkg::job_type push_data,
   input  logic              q_full
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int SW = umsa_pkg::SIZE_W;

   umsa_pkg::front_state_type state_ff, state_in;

   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;
   logic [CW-1:0] c_ff;
   logic [RW-1:0] r_ff;
   umsa_pkg::cell_type cur_ff;
   logic interior_ff, boundary_ff, fold_e_ff, fold_w_ff, fold_n_ff, fold_s_ff;

   logic [SW-1:0] gw, gh, w_eff, h_eff, c_ext, r_ext;
   logic [CW-1:0] c_now, c_sel;
   logic [RW-1:0] r_now;
   logic accept, go, wr_en;
   umsa_pkg::cell_type prev_c, prev_e, old_w, old_c;

   always_comb begin
      gw = SW'(cfg.grid_width);
      gh = SW'(cfg.grid_height);
      priority if (gw == '0) w_eff = SW'(1);
      else if (gw > SW'(MAX_WIDTH)) w_eff = SW'(MAX_WIDTH);
      else w_eff = gw;
      priority if (gh == '0) h_eff = SW'(1);
      else if (gh > SW'(MAX_HEIGHT)) h_eff = SW'(MAX_HEIGHT);
      else h_eff = gh;
      c_now = (SW'(col_cnt_ff) >= w_eff) ? '0 : col_cnt_ff;
      r_now = (SW'(row_cnt_ff) >= h_eff) ? '0 : row_cnt_ff;
      c_ext = SW'(c_now);
      r_ext = SW'(r_now);
      c_sel = (state_ff == umsa_pkg::F_IDLE) ? c_now : c_ff;
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      if (c_ext + SW'(1) >= w_eff) begin
         col_cnt_in = '0;
         row_cnt_in = (r_ext + SW'(1) >= h_eff) ? '0 : RW'(r_ext + SW'(1));
      end else begin
         col_cnt_in = CW'(c_ext + SW'(1));
         row_cnt_in = r_now;
      end
   end

   always_comb begin
      unique case (state_ff)
         umsa_pkg::F_IDLE: state_in = accept ? umsa_pkg::F_READ : umsa_pkg::F_IDLE;
         umsa_pkg::F_READ: state_in = go ? umsa_pkg::F_IDLE : umsa_pkg::F_READ;
         default:          state_in = umsa_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != umsa_pkg::F_IDLE);
      go        = (state_ff == umsa_pkg::F_READ) &&
                  (!(interior_ff || boundary_ff) || !q_full);
      wr_en     = go;
      push      = go && (interior_ff || boundary_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= umsa_pkg::F_IDLE;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff        <= c_now;
         r_ff        <= r_now;
         cur_ff      <= '{vx: req_vel_x, vy: req_vel_y, pr: req_cell_pressure};
         interior_ff <= (r_ext >= SW'(2)) && (c_ext >= SW'(1)) && (c_ext + SW'(1) < w_eff);
         boundary_ff <= (r_ext == '0) || (r_ext + SW'(1) == h_eff) ||
                        (c_ext == '0) || (c_ext + SW'(1) == w_eff);
         fold_e_ff   <= (c_ext + SW'(2) == w_eff);
         fold_w_ff   <= (c_ext == SW'(1));
         fold_n_ff   <= (r_ext + SW'(1) == h_eff);
         fold_s_ff   <= (r_ext == SW'(2));
      end
   end

   umsa_ram #(.WIDTH($bits(umsa_pkg::cell_type)), .DEPTH(MAX_WIDTH)) u_prev_row (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (c_ff),
      .wr_data   (cur_ff),
      .rd_addr_a (c_sel),
      .rd_addr_b (CW'(c_sel + 1'b1)),
      .rd_data_a (prev_c),
      .rd_data_b (prev_e)
   );

   umsa_ram #(.WIDTH($bits(umsa_pkg::cell_type)), .DEPTH(MAX_WIDTH)) u_older_row (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (c_ff),
      .wr_data   (prev_c),
      .rd_addr_a (CW'(c_sel - 1'b1)),
      .rd_addr_b (c_sel),
      .rd_data_a (old_w),
      .rd_data_b (old_c)
   );

   always_comb begin
      push_data.interior = interior_ff;
      push_data.boundary = boundary_ff;
      push_data.fold_e   = fold_e_ff;
      push_data.fold_w   = fold_w_ff;
      push_data.fold_n   = fold_n_ff;
      push_data.fold_s   = fold_s_ff;
      push_data.row      = 8'(r_ff);
      push_data.col      = 8'(c_ff);
      push_data.cur      = cur_ff;
      push_data.ctr      = prev_c;
      push_data.est      = prev_e;
      push_data.wst      = old_w;
      push_data.sth      = old_c;
   end

endmodule

// ----- rtl/umsa_back.sv -----
module umsa_back (
   input  logic              clock,
   input  logic              reset,
   input  umsa_pkg::cfg_type cfg,
   input  umsa_pkg::job_type q_head,
   input  logic              q_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_row,
   output logic [7:0]        rsp_out_col,
   output logic [31:0]       rsp_diag_coef,
   output logic [31:0]       rsp_east_entry,
   output logic [31:0]       rsp_west_entry,
   output logic [31:0]       rsp_north_entry,
   output logic [31:0]       rsp_south_entry,
   output logic [31:0]       rsp_rhs_value,
   output logic              rsp_last_of_run
);

   umsa_pkg::back_state_type state_ff, state_in;
   logic [umsa_pkg::STEP_W-1:0] step_ff;
   umsa_pkg::job_type job_ff;
   umsa_pkg::job_type bnd_src;

   logic signed [33:0] op_a;
   logic signed [31:0] op_b;
   logic signed [65:0] prod_in, prod_ff, prod_rnd;
   logic signed [49:0] rnd_val;
   logic signed [51:0] rnd_ext, rhs_ff, diag_sum;
   logic [30:0] ae_ff, aw_ff, an_ff, as_ff;
   logic load_int, load_bnd;

   function automatic logic signed [31:0] sel_vel(umsa_pkg::cell_type c, logic sel);
      sel_vel = sel ? c.vy : c.vx;
   endfunction

   function automatic logic signed [33:0] sx34(logic [31:0] v);
      sx34 = {{2{v[31]}}, v};
   endfunction

   function automatic logic [30:0] coef_sat(logic [30:0] d, logic signed [49:0] f,
                                            logic neg);
      logic signed [51:0] v;
      logic signed [51:0] p;
      v = neg ? -$signed({{2{f[49]}}, f}) : $signed({{2{f[49]}}, f});
      p = (v > 52'sd0) ? v : 52'sd0;
      p = p + $signed({21'd0, d});
      coef_sat = (p > umsa_pkg::COEF_HI) ? 31'h7FFF_FFFF : p[30:0];
   endfunction

   function automatic logic [31:0] sat_res(logic signed [51:0] x);
      priority if (x > umsa_pkg::RES_HI) sat_res = umsa_pkg::RES_HI[31:0];
      else if (x < umsa_pkg::RES_LO) sat_res = umsa_pkg::RES_LO[31:0];
      else sat_res = x[31:0];
   endfunction

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         4'd0: begin
            op_a = sx34(job_ff.ctr.vx) + sx34(job_ff.est.vx);
            op_b = $signed({1'b0, cfg.flux_scale_x});
         end
         4'd1: begin
            op_a = sx34(job_ff.ctr.vx) + sx34(job_ff.wst.vx);
            op_b = $signed({1'b0, cfg.flux_scale_x});
         end
         4'd2: begin
            op_a = sx34(job_ff.ctr.vy) + sx34(job_ff.cur.vy);
            op_b = $signed({1'b0, cfg.flux_scale_y});
         end
         4'd3: begin
            op_a = sx34(job_ff.ctr.vy) + sx34(job_ff.sth.vy);
            op_b = $signed({1'b0, cfg.flux_scale_y});
         end
         4'd4: begin
            op_a = cfg.component_select ? sx34(job_ff.sth.pr) - sx34(job_ff.cur.pr)
                                        : sx34(job_ff.wst.pr) - sx34(job_ff.est.pr);
            op_b = $signed({1'b0, cfg.gradient_scale});
         end
         4'd5: begin
            op_a = $signed({3'b000, ae_ff});
            op_b = sel_vel(job_ff.est, cfg.component_select);
         end
         4'd6: begin
            op_a = $signed({3'b000, aw_ff});
            op_b = sel_vel(job_ff.wst, cfg.component_select);
         end
         4'd7: begin
            op_a = $signed({3'b000, an_ff});
            op_b = sel_vel(job_ff.cur, cfg.component_select);
         end
         4'd8: begin
            op_a = $signed({3'b000, as_ff});
            op_b = sel_vel(job_ff.sth, cfg.component_select);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in  = op_a * op_b;
      prod_rnd = (prod_ff + 66'sd32768) >>> 16;
      rnd_val  = prod_rnd[49:0];
      rnd_ext  = {{2{rnd_val[49]}}, rnd_val};
      diag_sum = $signed({21'd0, ae_ff}) + $signed({21'd0, aw_ff}) +
                 $signed({21'd0, an_ff}) + $signed({21'd0, as_ff});
      bnd_src  = (state_ff == umsa_pkg::B_IDLE) ? q_head : job_ff;
   end

   always_comb begin
      unique case (state_ff)
         umsa_pkg::B_IDLE: begin
            priority if (q_empty) state_in = umsa_pkg::B_IDLE;
            else if (q_head.interior) state_in = umsa_pkg::B_CALC;
            else state_in = umsa_pkg::B_BND;
         end
         umsa_pkg::B_CALC:
            state_in = (step_ff == umsa_pkg::LAST_STEP) ? umsa_pkg::B_FIN : umsa_pkg::B_CALC;
         umsa_pkg::B_FIN: state_in = umsa_pkg::B_INT;
         umsa_pkg::B_INT: begin
            priority if (rsp_stall) state_in = umsa_pkg::B_INT;
            else if (job_ff.boundary) state_in = umsa_pkg::B_BND;
            else state_in = umsa_pkg::B_IDLE;
         end
         umsa_pkg::B_BND: state_in = rsp_stall ? umsa_pkg::B_BND : umsa_pkg::B_IDLE;
         default: state_in = umsa_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop       = (state_ff == umsa_pkg::B_IDLE) && !q_empty;
      rsp_valid = (state_ff == umsa_pkg::B_INT) || (state_ff == umsa_pkg::B_BND);
      load_int  = (state_ff == umsa_pkg::B_FIN);
      load_bnd  = (pop && !q_head.interior) ||
                  ((state_ff == umsa_pkg::B_INT) && !rsp_stall && job_ff.boundary);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= umsa_pkg::B_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            step_ff <= '0;
         end else if (state_ff == umsa_pkg::B_CALC) begin
            step_ff <= umsa_pkg::STEP_W'(step_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= q_head;
      end
      if (state_ff == umsa_pkg::B_CALC) begin
         prod_ff <= prod_in;
         unique case (step_ff)
            4'd1: ae_ff <= coef_sat(cfg.diffusion_x, rnd_val, 1'b1);
            4'd2: aw_ff <= coef_sat(cfg.diffusion_x, rnd_val, 1'b0);
            4'd3: an_ff <= coef_sat(cfg.diffusion_y, rnd_val, 1'b1);
            4'd4: as_ff <= coef_sat(cfg.diffusion_y, rnd_val, 1'b0);
            4'd5: rhs_ff <= rnd_ext;
            4'd6: if (job_ff.fold_e) rhs_ff <= rhs_ff + rnd_ext;
            4'd7: if (job_ff.fold_w) rhs_ff <= rhs_ff + rnd_ext;
            4'd8: if (job_ff.fold_n) rhs_ff <= rhs_ff + rnd_ext;
            4'd9: if (job_ff.fold_s) rhs_ff <= rhs_ff + rnd_ext;
            default: ;
         endcase
      end
      if (load_int) begin
         rsp_out_row     <= 8'(job_ff.row - 1'b1);
         rsp_out_col     <= job_ff.col;
         rsp_diag_coef   <= sat_res(diag_sum);
         rsp_east_entry  <= job_ff.fold_e ? '0 : 32'(-$signed({1'b0, ae_ff}));
         rsp_west_entry  <= job_ff.fold_w ? '0 : 32'(-$signed({1'b0, aw_ff}));
         rsp_north_entry <= job_ff.fold_n ? '0 : 32'(-$signed({1'b0, an_ff}));
         rsp_south_entry <= job_ff.fold_s ? '0 : 32'(-$signed({1'b0, as_ff}));
         rsp_rhs_value   <= sat_res(rhs_ff);
         rsp_last_of_run <= !job_ff.boundary;
      end else if (load_bnd) begin
         rsp_out_row     <= bnd_src.row;
         rsp_out_col     <= bnd_src.col;
         rsp_diag_coef   <= umsa_pkg::ONE_Q16;
         rsp_east_entry  <= '0;
         rsp_west_entry  <= '0;
         rsp_north_entry <= '0;
         rsp_south_entry <= '0;
         rsp_rhs_value   <= sel_vel(bnd_src.cur, cfg.component_select);
         rsp_last_of_run <= 1'b1;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty) else $error("pop from empty queue");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == umsa_pkg::B_CALC) |-> (step_ff <= umsa_pkg::LAST_STEP))
      else $error("step counter out of range");

   a_bnd_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == umsa_pkg::B_BND) |-> (job_ff.boundary && rsp_last_of_run))
      else $error("boundary result without boundary job");

   a_int_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == umsa_pkg::B_INT) |-> (rsp_last_of_run == !job_ff.boundary))
      else $error("interior result marks wrong end of run");

endmodule

// ----- rtl/upwind_momentum_stencil_assembler_unit.sv -----
// Five-point upwind momentum assembler in signed Q16.16. Cells enter in raster
// order; each accepted cell holds the input side for a row-store read, then a
// write-back that waits while the queue is full; a cell that yields an equation
// drops a job into a two-entry queue. A boundary-only job is offered the cycle
// after its pop. An interior equation uses the single shared multiplier (four
// face fluxes, the pressure gradient, four boundary folds) plus a finish step;
// a boundary equation of the same job follows it. No job is popped until the
// last is taken. The row stores have no reset and need no clearing.
module upwind_momentum_stencil_assembler_unit #(
   parameter int MAX_WIDTH  = umsa_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = umsa_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [umsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [umsa_pkg::COEF_W-1:0]      csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [31:0]                      req_vel_x,
   input  logic [31:0]                      req_vel_y,
   input  logic [31:0]                      req_cell_pressure,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_row,
   output logic [7:0]                       rsp_out_col,
   output logic [31:0]                      rsp_diag_coef,
   output logic [31:0]                      rsp_east_entry,
   output logic [31:0]                      rsp_west_entry,
   output logic [31:0]                      rsp_north_entry,
   output logic [31:0]                      rsp_south_entry,
   output logic [31:0]                      rsp_rhs_value,
   output logic                             rsp_last_of_run
);

   umsa_pkg::cfg_type cfg_ff;
   umsa_pkg::job_type push_data, q_head;
   logic push, pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                  <= '0;
         cfg_ff.grid_width       <= 9'd256;
         cfg_ff.grid_height      <= 9'd256;
      end else if (csr_write_enable) begin
         unique case (umsa_pkg::csr_index_type'(csr_index))
            umsa_pkg::CSR_GRID_WIDTH:     cfg_ff.grid_width       <= csr_data[8:0];
            umsa_pkg::CSR_GRID_HEIGHT:    cfg_ff.grid_height      <= csr_data[8:0];
            umsa_pkg::CSR_COMPONENT_SEL:  cfg_ff.component_select <= csr_data[0];
            umsa_pkg::CSR_DIFFUSION_X:    cfg_ff.diffusion_x      <= csr_data;
            umsa_pkg::CSR_DIFFUSION_Y:    cfg_ff.diffusion_y      <= csr_data;
            umsa_pkg::CSR_FLUX_SCALE_X:   cfg_ff.flux_scale_x     <= csr_data;
            umsa_pkg::CSR_FLUX_SCALE_Y:   cfg_ff.flux_scale_y     <= csr_data;
            umsa_pkg::CSR_GRADIENT_SCALE: cfg_ff.gradient_scale   <= csr_data;
            default: ;
         endcase
      end
   end

   umsa_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .req_cell_pressure (req_cell_pressure),
      .push              (push),
      .push_data         (push_data),
      .q_full            (q_full)
   );

   umsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   umsa_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_diag_coef   (rsp_diag_coef),
      .rsp_east_entry  (rsp_east_entry),
      .rsp_west_entry  (rsp_west_entry),
      .rsp_north_entry (rsp_north_entry),
      .rsp_south_entry (rsp_south_entry),
      .rsp_rhs_value   (rsp_rhs_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- bench/upwind_momentum_stencil_assembler_unit_tb.sv -----
`timescale 1ns / 1ps

module upwind_momentum_stencil_assembler_unit_tb;

   typedef struct {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] diag;
      logic [31:0] east;
      logic [31:0] west;
      logic [31:0] north;
      logic [31:0] south;
      logic [31:0] rhs;
      logic        last;
   } equation_type;

   typedef struct {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] pr;
      bit          typed;
   } directed_cell_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_CELLS    = 120;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [umsa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [umsa_pkg::COEF_W-1:0]      csr_data;
   logic                             req_valid;
   logic                             req_stall;
   logic [31:0]                      req_vel_x;
   logic [31:0]                      req_vel_y;
   logic [31:0]                      req_cell_pressure;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [7:0]                       rsp_out_row;
   logic [7:0]                       rsp_out_col;
   logic [31:0]                      rsp_diag_coef;
   logic [31:0]                      rsp_east_entry;
   logic [31:0]                      rsp_west_entry;
   logic [31:0]                      rsp_north_entry;
   logic [31:0]                      rsp_south_entry;
   logic [31:0]                      rsp_rhs_value;
   logic                             rsp_last_of_run;

   upwind_momentum_stencil_assembler_unit dut (.*);

   // predictor state
   umsa_pkg::cell_type prev_row [256];
   umsa_pkg::cell_type older_row[256];
   int                row_cnt;
   int                col_cnt;
   logic [8:0]        cfg_width;
   logic [8:0]        cfg_height;
   logic              cfg_comp;
   logic [30:0]       cfg_diff_x;
   logic [30:0]       cfg_diff_y;
   logic [30:0]       cfg_flux_x;
   logic [30:0]       cfg_flux_y;
   logic [30:0]       cfg_grad;

   equation_type      pending_eqs[$];
   equation_type      step_eqs[$];
   int                errors;
   int                cells_sent;
   int                eqs_seen;
   int                interior_eqs;
   int                idle_pct;
   int                stall_pct;
   int                quiet_cycles;

   directed_cell_type directed_cells[22] = '{
      '{32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000, 1'b1},
      '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 1'b1},
      '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1},
      '{32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0},
      '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0},
      '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0},
      '{32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 1'b0},
      '{32'hffff_0000, 32'h0001_8000, 32'hfffe_0000, 1'b0},
      '{32'h0000_4000, 32'hfffc_0000, 32'h0003_0000, 1'b0},
      '{32'h0002_0000, 32'hffff_8000, 32'h0001_0000, 1'b0},
      '{32'hfffe_0000, 32'h0003_0000, 32'hffff_0000, 1'b0},
      '{32'h0000_8000, 32'hfffd_0000, 32'h0004_0000, 1'b0},
      '{32'h0001_8000, 32'h0000_c000, 32'hfffc_0000, 1'b0},
      '{32'hffff_4000, 32'h0002_4000, 32'h0000_0000, 1'b0},
      '{32'h0003_0000, 32'hfffe_8000, 32'h0002_0000, 1'b0}
   };

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint sx(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint round_q16(longint x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic longint sat_result(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint sat_coef(longint x);
      if (x < 0) return 0;
      if (x > 64'sd2147483647) return 64'sd2147483647;
      return x;
   endfunction

   function automatic longint positive(longint x);
      return (x > 0) ? x : 0;
   endfunction

   function automatic int grid_size(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic longint selected_vel(umsa_pkg::cell_type c);
      return cfg_comp ? sx(c.vy) : sx(c.vx);
   endfunction

   function automatic equation_type make_eq(int row, int col, longint diag, longint e,
                                           longint w, longint n, longint s, longint rhs);
      equation_type q;
      q.row = row[7:0];
      q.col = col[7:0];
      q.diag = diag[31:0];
      q.east = e[31:0];
      q.west = w[31:0];
      q.north = n[31:0];
      q.south = s[31:0];
      q.rhs = rhs[31:0];
      q.last = 1'b0;
      return q;
   endfunction

   function automatic void fold_neighbor(bit on_edge, longint a, longint vel,
                                         output longint entry, inout longint rhs);
      if (on_edge) begin
         entry = 0;
         rhs += round_q16(a * vel);
      end else begin
         entry = -a;
      end
   endfunction

   // advance the stencil by one cell; equations land in step_eqs
   function automatic void assemble_cell(umsa_pkg::cell_type cur);
      int       w;
      int       h;
      int       r;
      int       c;
      umsa_pkg::cell_type ctr;
      umsa_pkg::cell_type est;
      umsa_pkg::cell_type wst;
      umsa_pkg::cell_type sth;
      longint   fe, fw, fn, fs, ae, aw, an, as_, dp, rhs, ee, we, ne, se;
      w = grid_size(cfg_width);
      h = grid_size(cfg_height);
      step_eqs.delete();
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      r = row_cnt;
      c = col_cnt;
      if (r >= 2 && c >= 1 && c + 1 < w) begin
         ctr = prev_row[c];
         est = prev_row[c + 1];
         wst = older_row[c - 1];
         sth = older_row[c];
         fe = round_q16((sx(ctr.vx) + sx(est.vx)) * longint'(cfg_flux_x));
         fw = round_q16((sx(ctr.vx) + sx(wst.vx)) * longint'(cfg_flux_x));
         fn = round_q16((sx(ctr.vy) + sx(cur.vy)) * longint'(cfg_flux_y));
         fs = round_q16((sx(ctr.vy) + sx(sth.vy)) * longint'(cfg_flux_y));
         ae = sat_coef(longint'(cfg_diff_x) + positive(-fe));
         aw = sat_coef(longint'(cfg_diff_x) + positive(fw));
         an = sat_coef(longint'(cfg_diff_y) + positive(-fn));
         as_ = sat_coef(longint'(cfg_diff_y) + positive(fs));
         dp = cfg_comp ? sx(cur.pr) - sx(sth.pr) : sx(est.pr) - sx(wst.pr);
         rhs = round_q16(-dp * longint'(cfg_grad));
         fold_neighbor(c + 2 == w, ae, selected_vel(est), ee, rhs);
         fold_neighbor(c == 1, aw, selected_vel(wst), we, rhs);
         fold_neighbor(r + 1 == h, an, selected_vel(cur), ne, rhs);
         fold_neighbor(r == 2, as_, selected_vel(sth), se, rhs);
         step_eqs.push_back(make_eq(r - 1, c, sat_result(ae + aw + an + as_), ee, we, ne,
                                    se, sat_result(rhs)));
         interior_eqs++;
      end
      if (r == 0 || r + 1 == h || c == 0 || c + 1 == w)
         step_eqs.push_back(make_eq(r, c, umsa_pkg::ONE_Q16, 0, 0, 0, 0,
                                    selected_vel(cur)));
      if (step_eqs.size() > 0) step_eqs[step_eqs.size() - 1].last = 1'b1;
      older_row[c] = prev_row[c];
      prev_row[c] = cur;
      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   task automatic write_reg(umsa_pkg::csr_index_type idx, logic [30:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
   endtask

   task automatic configure(logic [8:0] w, logic [8:0] h, logic comp, logic [30:0] dx,
                            logic [30:0] dy, logic [30:0] fx, logic [30:0] fy,
                            logic [30:0] gs);
      write_reg(umsa_pkg::CSR_GRID_WIDTH, 31'(w));
      write_reg(umsa_pkg::CSR_GRID_HEIGHT, 31'(h));
      write_reg(umsa_pkg::CSR_COMPONENT_SEL, 31'(comp));
      write_reg(umsa_pkg::CSR_DIFFUSION_X, dx);
      write_reg(umsa_pkg::CSR_DIFFUSION_Y, dy);
      write_reg(umsa_pkg::CSR_FLUX_SCALE_X, fx);
      write_reg(umsa_pkg::CSR_FLUX_SCALE_Y, fy);
      write_reg(umsa_pkg::CSR_GRADIENT_SCALE, gs);
      csr_write_enable <= 1'b0;
      cfg_width = w;
      cfg_height = h;
      cfg_comp = comp;
      cfg_diff_x = dx;
      cfg_diff_y = dy;
      cfg_flux_x = fx;
      cfg_flux_y = fy;
      cfg_grad = gs;
   endtask

   // hold the sender until every equation is out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_eqs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_cell(umsa_pkg::cell_type cell_data, bit predicted);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vel_x <= cell_data.vx;
      req_vel_y <= cell_data.vy;
      req_cell_pressure <= cell_data.pr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      assemble_cell(cell_data);
      cells_sent++;
      if (predicted)
         foreach (step_eqs[i]) pending_eqs.push_back(step_eqs[i]);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_field();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 524288) - 262144;
         6, 7: return $urandom;
         8: return 32'h7fff_ffff;
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [30:0] random_coef(int phase);
      if (phase == 1) return 31'h7fff_ffff;
      if (phase == 2) return 31'd0;
      case ($urandom_range(5))
         0: return 31'd0;
         1: return 31'h7fff_ffff;
         2, 3: return 31'($urandom_range(0, 262144));
         default: return 31'($urandom);
      endcase
   endfunction

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      equation_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         eqs_seen++;
         if (pending_eqs.size() == 0) begin
            $display("unexpected equation row %0d col %0d", rsp_out_row, rsp_out_col);
            errors++;
         end else begin
            want = pending_eqs.pop_front();
            if (rsp_out_row !== want.row) report("row", 32'(rsp_out_row), 32'(want.row));
            if (rsp_out_col !== want.col) report("col", 32'(rsp_out_col), 32'(want.col));
            if (rsp_diag_coef !== want.diag) report("diag", rsp_diag_coef, want.diag);
            if (rsp_east_entry !== want.east) report("east", rsp_east_entry, want.east);
            if (rsp_west_entry !== want.west) report("west", rsp_west_entry, want.west);
            if (rsp_north_entry !== want.north)
               report("north", rsp_north_entry, want.north);
            if (rsp_south_entry !== want.south)
               report("south", rsp_south_entry, want.south);
            if (rsp_rhs_value !== want.rhs) report("rhs", rsp_rhs_value, want.rhs);
            if (rsp_last_of_run !== want.last)
               report("last", 32'(rsp_last_of_run), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      umsa_pkg::cell_type cell_data;
      equation_type typed_eq;
      int           w;
      int           h;
      int           phase_cells;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = umsa_pkg::CSR_GRID_WIDTH;
      csr_data = '0;
      req_valid = 1'b0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_cell_pressure = '0;
      rsp_stall = 1'b0;
      errors = 0;
      cells_sent = 0;
      eqs_seen = 0;
      interior_eqs = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      row_cnt = 0;
      col_cnt = 0;
      cfg_width = 9'd256;
      cfg_height = 9'd256;
      cfg_comp = 1'b0;
      cfg_diff_x = '0;
      cfg_diff_y = '0;
      cfg_flux_x = '0;
      cfg_flux_y = '0;
      cfg_grad = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_cells[i]) begin
         if (i == 4)
            configure(9'd3, 9'd3, 1'b0, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                      31'h7fff_ffff, 31'h7fff_ffff);
         if (i == 13) begin
            drain();
            configure(9'd3, 9'd3, 1'b1, 31'h0001_0000, 31'h0000_8000, 31'h0000_8000,
                      31'h0001_0000, 31'h0000_4000);
         end
         cell_data = '{directed_cells[i].vx, directed_cells[i].vy, directed_cells[i].pr};
         send_cell(cell_data, !directed_cells[i].typed);
         if (directed_cells[i].typed) begin
            // reset grid: top row, identity diagonal, rhs is the x velocity
            typed_eq = make_eq(0, i, umsa_pkg::ONE_Q16, 0, 0, 0, 0,
                               sx(directed_cells[i].vx));
            typed_eq.last = 1'b1;
            pending_eqs.push_back(typed_eq);
         end
         if (i == 3) drain();
      end
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 45; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 45; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         case (phase)
            3: begin w = 0; h = $urandom_range(1, 6); end
            4: begin w = 300; h = 1; end
            5: begin w = $urandom_range(3, 10); h = 0; end
            8: begin w = 3; h = 3; end
            default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 8); end
         endcase
         configure(9'(w), 9'(h), 1'($urandom_range(1)), random_coef(phase),
                   random_coef(phase), random_coef(phase), random_coef(phase),
                   random_coef(phase));
         phase_cells = 0;
         while (phase_cells < PHASE_CELLS) begin
            for (int k = 0; k < grid_size(9'(w)) * grid_size(9'(h)); k++) begin
               cell_data = '{random_field(), random_field(), random_field()};
               send_cell(cell_data, 1'b1);
               phase_cells++;
            end
            if (phase == 6 && phase_cells < PHASE_CELLS) drain();
         end
         drain();
      end

      if (pending_eqs.size() != 0) begin
         $display("%0d equations never arrived", pending_eqs.size());
         errors++;
      end
      $display("covered %0d cells and %0d equations (%0d interior) over 14 grid settings",
               cells_sent, eqs_seen, interior_eqs);
      $display("idle modes: none, sender gaps, receiver stalls, both");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
